// File: design/tlsam_pkg.sv
// Package for the two-level span address map.
// Holds the request and response payload types, request codes, sequencer states and defaults.
// Depends on nothing; tlsam_seq and the top level import it.
package tlsam_pkg;

   localparam int ADDR_BITS  = 48;
   localparam int L1_SHIFT   = 32;
   localparam int L2_SHIFT   = 16;
   localparam int BLK_BITS   = ADDR_BITS - L2_SHIFT;
   localparam int SLOT_OFS   = L1_SHIFT - L2_SHIFT;
   localparam int COUNT_BITS = 5;
   localparam int ID_BITS    = 10;

   localparam int FIRST_LEVEL_BITS_DEF  = 16;
   localparam int SECOND_LEVEL_BITS_DEF = 16;
   localparam int LEAF_POOL_DEF         = 16;
   localparam int MAX_BLOCKS_DEF        = 16;
   localparam int DESC_BITS_DEF         = 10;

   localparam logic [1:0] REQ_LOOKUP     = 2'd0;
   localparam logic [1:0] REQ_REGISTER   = 2'd1;
   localparam logic [1:0] REQ_UNREGISTER = 2'd2;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [ADDR_BITS-1:0]  address;
      logic [COUNT_BITS-1:0] block_count;
      logic [ID_BITS-1:0]    descriptor;
   } req_payload_type;

   typedef struct packed {
      logic               found;
      logic [ID_BITS-1:0] span_id;
      logic               status;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK_LEAF,
      ST_LOOK_ENTRY,
      ST_BLK_READ,
      ST_BLK_UPDATE
   } state_type;

endpackage

// File: design/tlsam_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Used for the first-level slot table and the leaf store; no dependencies.
module tlsam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/tlsam_seq.sv
// Request sequencer for the two-level span address map.
// Walks the first-level table and the leaf store held in two tlsam_ram instances.
// Depends on tlsam_pkg.
module tlsam_seq #(
   parameter int FIRST_LEVEL_BITS  = tlsam_pkg::FIRST_LEVEL_BITS_DEF,
   parameter int SECOND_LEVEL_BITS = tlsam_pkg::SECOND_LEVEL_BITS_DEF,
   parameter int LEAF_POOL         = tlsam_pkg::LEAF_POOL_DEF,
   parameter int MAX_BLOCKS        = tlsam_pkg::MAX_BLOCKS_DEF,
   parameter int DESC_BITS         = tlsam_pkg::DESC_BITS_DEF,
   localparam int LEAF_BITS = (LEAF_POOL > 1) ? $clog2(LEAF_POOL) : 1,
   localparam int LS_AW     = LEAF_BITS + SECOND_LEVEL_BITS,
   localparam int DW        = (DESC_BITS < tlsam_pkg::ID_BITS) ? DESC_BITS : tlsam_pkg::ID_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tlsam_pkg::req_payload_type    req_item,
   output logic                          rsp_valid,
   output tlsam_pkg::rsp_payload_type    rsp_item,
   output logic                          fl_we,
   output logic [FIRST_LEVEL_BITS-1:0]   fl_addr,
   output logic [LEAF_BITS:0]            fl_wdata,
   input  logic [LEAF_BITS:0]            fl_rdata,
   output logic                          ls_we,
   output logic [LS_AW-1:0]              ls_addr,
   output logic [DW-1:0]                 ls_wdata,
   input  logic [DW-1:0]                 ls_rdata
);

   import tlsam_pkg::*;

   localparam int CLRW = (FIRST_LEVEL_BITS > LS_AW) ? FIRST_LEVEL_BITS : LS_AW;
   localparam int CNTW = $clog2(LEAF_POOL + 1);
   localparam int LW   = $clog2(MAX_BLOCKS + 1);

   state_type             state_ff, state_in;
   req_payload_type       req_ff, req_in;
   logic [BLK_BITS-1:0]   blk_ff, blk_in;
   logic [LW-1:0]         left_ff, left_in;
   logic [CNTW-1:0]       leaves_ff, leaves_in;
   logic [CLRW-1:0]       clr_ff, clr_in;
   rsp_payload_type       rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [6:0]                   count_sat;
   logic [FIRST_LEVEL_BITS-1:0]  cur_slot;
   logic [SECOND_LEVEL_BITS-1:0] cur_entry;
   logic                         is_reg;
   logic                         slot_hit;
   logic [LEAF_BITS-1:0]         slot_leaf;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         leaves_ff    <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         leaves_ff    <= leaves_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      blk_ff  <= blk_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   assign cur_slot  = blk_ff[SLOT_OFS +: FIRST_LEVEL_BITS];
   assign cur_entry = blk_ff[SECOND_LEVEL_BITS-1:0];
   assign is_reg    = (req_ff.req_type == REQ_REGISTER);
   assign slot_hit  = fl_rdata[LEAF_BITS];
   assign slot_leaf = fl_rdata[LEAF_BITS-1:0];

   always_comb begin
      count_sat = 7'(req_item.block_count);
      if (count_sat > 7'(MAX_BLOCKS)) begin
         count_sat = 7'(MAX_BLOCKS);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      blk_in       = blk_ff;
      left_in      = left_ff;
      leaves_in    = leaves_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      busy         = 1'b1;
      fl_we        = 1'b0;
      fl_addr      = cur_slot;
      fl_wdata     = '0;
      ls_we        = 1'b0;
      ls_addr      = {slot_leaf, cur_entry};
      ls_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            fl_we   = (32'(clr_ff) < (32'd1 << FIRST_LEVEL_BITS));
            fl_addr = clr_ff[FIRST_LEVEL_BITS-1:0];
            ls_we   = 1'b1;
            ls_addr = clr_ff[LS_AW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy    = 1'b0;
            fl_addr = req_item.address[L1_SHIFT +: FIRST_LEVEL_BITS];
            if (start) begin
               req_in  = req_item;
               blk_in  = req_item.address[ADDR_BITS-1:L2_SHIFT];
               left_in = LW'(count_sat);
               if (req_item.req_type == REQ_LOOKUP) begin
                  state_in = ST_LOOK_LEAF;
               end else if ((req_item.req_type == REQ_REGISTER ||
                             req_item.req_type == REQ_UNREGISTER) && count_sat != 7'd0) begin
                  state_in = ST_BLK_UPDATE;
               end else begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_LOOK_LEAF: begin
            if (slot_hit) begin
               state_in = ST_LOOK_ENTRY;
            end else begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LOOK_ENTRY: begin
            rsp_in         = '0;
            rsp_in.found   = |ls_rdata;
            rsp_in.span_id = ID_BITS'(ls_rdata);
            rsp_valid_in   = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_BLK_READ: begin
            state_in = ST_BLK_UPDATE;
         end
         ST_BLK_UPDATE: begin
            if (!slot_hit && is_reg && leaves_ff >= CNTW'(LEAF_POOL)) begin
               rsp_in        = '0;
               rsp_in.status = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               if (slot_hit) begin
                  ls_we    = 1'b1;
                  ls_wdata = is_reg ? req_ff.descriptor[DW-1:0] : '0;
               end else if (is_reg) begin
                  fl_we     = 1'b1;
                  fl_wdata  = {1'b1, leaves_ff[LEAF_BITS-1:0]};
                  ls_we     = 1'b1;
                  ls_addr   = {leaves_ff[LEAF_BITS-1:0], cur_entry};
                  ls_wdata  = req_ff.descriptor[DW-1:0];
                  leaves_in = leaves_ff + 1'b1;
               end
               if (left_ff == LW'(1)) begin
                  rsp_in       = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  left_in  = left_ff - 1'b1;
                  blk_in   = blk_ff + 1'b1;
                  state_in = ST_BLK_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_leaves_bound: assert property (@(posedge clock) disable iff (reset)
      leaves_ff <= CNTW'(LEAF_POOL))
      else $error("leaf pool counter ran past the pool size");

   a_leaves_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (leaves_ff == $past(leaves_ff)) || (leaves_ff == $past(leaves_ff) + 1'b1))
      else $error("leaf pool counter moved by more than one");

   a_status_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> req_ff.req_type == REQ_REGISTER)
      else $error("pool exhaustion reported for a request other than register");

   a_found_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.found |-> rsp_ff.span_id != '0 && !rsp_ff.status)
      else $error("hit reported with an empty descriptor");

   a_fl_write: assert property (@(posedge clock) disable iff (reset)
      fl_we |-> state_ff == ST_CLEAR || (state_ff == ST_BLK_UPDATE && is_reg && !slot_hit))
      else $error("first-level table written outside clearing or leaf allocation");

endmodule

// File: design/two_level_span_address_map.sv
// Top level of the two-level span address map: block address to span descriptor.
// Instantiates tlsam_seq and two tlsam_ram memories; depends on tlsam_pkg.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      transfer when start is high and busy is low
//   response  rsp_valid, rsp_item        one-cycle strobe, always taken
//
// A lookup reads the first-level table and then the leaf store, each through a registered
// RAM port; a lookup whose slot has no leaf stops after the first read. Busy stays high
// until a request finishes, so a new request is taken only once the last one is done.
// Register and unregister read the slot and then update it, block by block, for N blocks,
// or up to the failing block when the leaf pool runs out; a zero count or an unknown
// request type is answered from idle without a memory walk.
// After reset both memories are swept to zero, one entry a cycle, over
// 2**max(FIRST_LEVEL_BITS, leaf index bits + SECOND_LEVEL_BITS) addresses with busy high.
// The response appears the cycle after the request finishes; the receiver cannot stall.
module two_level_span_address_map #(
   parameter int FIRST_LEVEL_BITS  = tlsam_pkg::FIRST_LEVEL_BITS_DEF,
   parameter int SECOND_LEVEL_BITS = tlsam_pkg::SECOND_LEVEL_BITS_DEF,
   parameter int LEAF_POOL         = tlsam_pkg::LEAF_POOL_DEF,
   parameter int MAX_BLOCKS        = tlsam_pkg::MAX_BLOCKS_DEF,
   parameter int DESC_BITS         = tlsam_pkg::DESC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  tlsam_pkg::req_payload_type req_item,
   output logic                       rsp_valid,
   output tlsam_pkg::rsp_payload_type rsp_item
);

   import tlsam_pkg::*;

   localparam int LEAF_BITS = (LEAF_POOL > 1) ? $clog2(LEAF_POOL) : 1;
   localparam int LS_AW     = LEAF_BITS + SECOND_LEVEL_BITS;
   localparam int DW        = (DESC_BITS < ID_BITS) ? DESC_BITS : ID_BITS;

   logic                        fl_we;
   logic [FIRST_LEVEL_BITS-1:0] fl_addr;
   logic [LEAF_BITS:0]          fl_wdata;
   logic [LEAF_BITS:0]          fl_rdata;
   logic                        ls_we;
   logic [LS_AW-1:0]            ls_addr;
   logic [DW-1:0]               ls_wdata;
   logic [DW-1:0]               ls_rdata;

   tlsam_seq #(
      .FIRST_LEVEL_BITS  (FIRST_LEVEL_BITS),
      .SECOND_LEVEL_BITS (SECOND_LEVEL_BITS),
      .LEAF_POOL         (LEAF_POOL),
      .MAX_BLOCKS        (MAX_BLOCKS),
      .DESC_BITS         (DESC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .fl_we     (fl_we),
      .fl_addr   (fl_addr),
      .fl_wdata  (fl_wdata),
      .fl_rdata  (fl_rdata),
      .ls_we     (ls_we),
      .ls_addr   (ls_addr),
      .ls_wdata  (ls_wdata),
      .ls_rdata  (ls_rdata)
   );

   tlsam_ram #(
      .WIDTH (LEAF_BITS + 1),
      .DEPTH (2 ** FIRST_LEVEL_BITS)
   ) u_first_level (
      .clock (clock),
      .we    (fl_we),
      .addr  (fl_addr),
      .wdata (fl_wdata),
      .rdata (fl_rdata)
   );

   tlsam_ram #(
      .WIDTH (DW),
      .DEPTH (2 ** LS_AW)
   ) u_leaf_store (
      .clock (clock),
      .we    (ls_we),
      .addr  (ls_addr),
      .wdata (ls_wdata),
      .rdata (ls_rdata)
   );

endmodule

// File: test/testbench.sv
// Self-checking testbench for two_level_span_address_map: lookups, span register and
// unregister requests and reserved request codes are checked against a behavioral model of the two-level map.
// Depends on tlsam_pkg and the two_level_span_address_map design files.
`timescale 1ns / 1ps

module testbench;
   import tlsam_pkg::*;

   localparam logic [1:0] REQ_RESERVED = 2'd3;
   localparam int LEAF_COUNT     = LEAF_POOL_DEF;
   localparam int SPAN_LIMIT     = MAX_BLOCKS_DEF;
   localparam int ENTRY_COUNT    = 1 << SECOND_LEVEL_BITS_DEF;
   localparam int SLOT_COUNT     = 1 << FIRST_LEVEL_BITS_DEF;
   localparam int RANDOM_ITEMS   = 750;
   localparam int TAIL_CYCLES    = 2 * SPAN_LIMIT + 8;
   localparam int WATCHDOG_LIMIT = 3200000;

   logic            clock = 1'b0;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_item;
   logic            rsp_valid;
   rsp_payload_type rsp_item;

   req_payload_type request_queue [$];
   rsp_payload_type expected_responses [$];
   logic [47:0]     recent_bases [$];
   logic            took_item = 1'b0;
   int              accepted_items = 0;
   int              error_count = 0;
   int              quiet_cycles = 0;

   bit              slot_valid [SLOT_COUNT];
   bit [4:0]        slot_leaf [SLOT_COUNT];
   bit [9:0]        leaf_entries [LEAF_COUNT * ENTRY_COUNT];
   int unsigned     leaves_taken = 0;

   two_level_span_address_map u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Applies one request to the model state and returns the response it should produce.
   function automatic rsp_payload_type map_response(input req_payload_type r);
      rsp_payload_type res;
      logic [63:0]     blk_addr;
      int unsigned     slot;
      int unsigned     idx;
      int unsigned     span;
      int unsigned     k;
      res = '0;
      span = r.block_count;
      if (span > SPAN_LIMIT) begin
         span = SPAN_LIMIT;
      end
      case (r.req_type)
         REQ_LOOKUP: begin
            slot = r.address[47:32];
            idx = r.address[31:16];
            if (slot_valid[slot] && leaf_entries[slot_leaf[slot] * ENTRY_COUNT + idx] != 0) begin
               res.found = 1'b1;
               res.span_id = leaf_entries[slot_leaf[slot] * ENTRY_COUNT + idx];
            end
         end
         REQ_REGISTER: begin
            for (k = 0; k < span && !res.status; k++) begin
               blk_addr = {16'd0, r.address} + (64'(k) << 16);
               slot = blk_addr[47:32];
               idx = blk_addr[31:16];
               if (!slot_valid[slot] && leaves_taken >= LEAF_COUNT) begin
                  res.status = 1'b1;
               end else begin
                  if (!slot_valid[slot]) begin
                     slot_valid[slot] = 1'b1;
                     slot_leaf[slot] = 5'(leaves_taken);
                     leaves_taken++;
                  end
                  leaf_entries[slot_leaf[slot] * ENTRY_COUNT + idx] = r.descriptor;
               end
            end
         end
         REQ_UNREGISTER: begin
            for (k = 0; k < span; k++) begin
               blk_addr = {16'd0, r.address} + (64'(k) << 16);
               slot = blk_addr[47:32];
               idx = blk_addr[31:16];
               if (slot_valid[slot]) begin
                  leaf_entries[slot_leaf[slot] * ENTRY_COUNT + idx] = '0;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic req_payload_type make_request(input logic [1:0] kind,
                                                    input logic [47:0] addr,
                                                    input int count, input int desc);
      req_payload_type r;
      r.req_type = kind;
      r.address = addr;
      r.block_count = 5'(count);
      r.descriptor = 10'(desc);
      return r;
   endfunction

   // Most addresses fall in a few slots, so leaves run out and lookups hit written entries.
   function automatic logic [47:0] hot_address();
      logic [15:0] slot;
      logic [15:0] idx;
      if ($urandom_range(0, 9) == 0) begin
         slot = 16'($urandom_range(0, 65535));
      end else begin
         slot = 16'($urandom_range(0, 19));
         if (slot >= 10) begin
            slot = 16'hFFF6 + slot - 16'd10;
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         idx = 16'hFFF0 + 16'($urandom_range(0, 15));
      end else begin
         idx = 16'($urandom_range(0, 63));
      end
      return {slot, idx, 16'($urandom_range(0, 65535))};
   endfunction

   function automatic logic [47:0] near_recent();
      logic [47:0] base;
      if (recent_bases.size() == 0) begin
         return hot_address();
      end
      base = recent_bases[$urandom_range(0, recent_bases.size() - 1)];
      return {base[47:16] + 32'($urandom_range(0, 16)), 16'($urandom_range(0, 65535))};
   endfunction

   function automatic int random_count();
      if ($urandom_range(0, 4) == 0) begin
         return $urandom_range(0, 31);
      end
      return $urandom_range(1, 16);
   endfunction

   function automatic int sender_idle_pct();
      case ((accepted_items / 120) % 4)
         1: return 52;
         3: return 7;
         default: return 0;
      endcase
   endfunction

   initial begin
      logic [47:0] addr;
      int          pick;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;

      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0000_0000, 1, 1));
      request_queue.push_back(make_request(REQ_REGISTER, 48'h0000_0000_0000, 1, 1023));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0000_0000, 1, 1));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0001_0000, 1, 1));
      request_queue.push_back(make_request(REQ_REGISTER, 48'hFFFF_FFFF_0000, 3, 5));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 1, 1));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0001_ABCD, 1, 1));
      request_queue.push_back(make_request(REQ_REGISTER, 48'h0000_0010_1234, 0, 7));
      request_queue.push_back(make_request(REQ_REGISTER, 48'h0000_0002_8001, 31, 9));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0011_0000, 1, 1));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0012_0000, 1, 1));
      request_queue.push_back(make_request(REQ_REGISTER, 48'h0000_0003_0000, 1, 0));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0003_0000, 1, 1));
      request_queue.push_back(make_request(REQ_UNREGISTER, 48'h0000_0002_0000, 2, 0));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_0002_8000, 1, 1));
      request_queue.push_back(make_request(REQ_UNREGISTER, 48'h1234_0000_0000, 16, 0));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h1234_0000_0000, 1, 1));
      request_queue.push_back(make_request(REQ_UNREGISTER, 48'h0000_0000_0000, 0, 0));
      request_queue.push_back(make_request(REQ_RESERVED, 48'hFFFF_FFFF_FFFF, 31, 1023));
      request_queue.push_back(make_request(REQ_REGISTER, 48'hFFFF_FFFF_0000, 16, 512));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'h0000_000E_0000, 1, 1));
      request_queue.push_back(make_request(REQ_LOOKUP, 48'hFFFF_FFFF_FFFF, 1, 1));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            addr = hot_address();
            request_queue.push_back(make_request(REQ_REGISTER, addr, random_count(),
                                                 $urandom_range(0, 1023)));
            recent_bases.push_back(addr);
            if (recent_bases.size() > 24) begin
               void'(recent_bases.pop_front());
            end
         end else if (pick < 75) begin
            addr = ($urandom_range(0, 4) == 0) ? hot_address() : near_recent();
            request_queue.push_back(make_request(REQ_LOOKUP, addr, $urandom_range(0, 31),
                                                 $urandom_range(0, 1023)));
         end else if (pick < 90) begin
            request_queue.push_back(make_request(REQ_UNREGISTER, near_recent(), random_count(),
                                                 $urandom_range(0, 1023)));
         end else if (pick < 95) begin
            request_queue.push_back(make_request(REQ_RESERVED, hot_address(),
                                                 $urandom_range(0, 31), $urandom_range(0, 1023)));
         end else begin
            addr = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535))};
            request_queue.push_back(make_request(2'($urandom_range(0, 3)), addr,
                                                 $urandom_range(0, 31), $urandom_range(0, 1023)));
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || start || expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (!reset && (!start || took_item)) begin
         if (request_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
            req_item <= request_queue.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      took_item <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               flag_error($sformatf("response with no request outstanding: %h", rsp_item));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_item.found !== want.found) begin
                  flag_error($sformatf("found %b, expected %b", rsp_item.found, want.found));
               end
               if (rsp_item.span_id !== want.span_id) begin
                  flag_error($sformatf("span_id %0d, expected %0d",
                                       rsp_item.span_id, want.span_id));
               end
               if (rsp_item.status !== want.status) begin
                  flag_error($sformatf("status %b, expected %b", rsp_item.status, want.status));
               end
            end
         end
         if (start && !busy) begin
            expected_responses.push_back(map_response(req_item));
            accepted_items <= accepted_items + 1;
         end
      end
   end

   // The clearing sweep after reset keeps busy high with no transfer; the watchdog limit allows for it.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
